// ----- rtl/x64e_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the instruction form table for the x64 byte encoder.
// No dependencies.
package x64e_pkg;

    localparam int MAX_BYTES   = 10;
    localparam int CNT_W       = 4;
    localparam int FRAME_W     = 8 * MAX_BYTES;

    // Layout of the bytes after the opcode.
    localparam logic [1:0] KIND_MODRM_REG = 2'd0;
    localparam logic [1:0] KIND_OPC_REG   = 2'd1;
    localparam logic [1:0] KIND_MODRM_IMM = 2'd2;

    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] REX_BASE   = 8'h40;
    localparam logic [7:0] OPC_ADD_RM_R = 8'h01;
    localparam logic [7:0] OPC_ADD_R_RM = 8'h03;
    localparam logic [7:0] OPC_MOV_RM_R = 8'h89;
    localparam logic [7:0] OPC_MOV_R_RM = 8'h8B;
    localparam logic [7:0] OPC_MOV_R8_I = 8'hB0;
    localparam logic [7:0] OPC_MOV_R_I  = 8'hB8;
    localparam logic [7:0] OPC_MOV_RM8_I = 8'hC6;
    localparam logic [7:0] OPC_MOV_RM_I = 8'hC7;

    localparam logic [4:0] CMD_ADD_RM16_R16  = 5'd0;
    localparam logic [4:0] CMD_ADD_R16_RM16  = 5'd1;
    localparam logic [4:0] CMD_ADD_RM32_R32  = 5'd2;
    localparam logic [4:0] CMD_ADD_R32_RM32  = 5'd3;
    localparam logic [4:0] CMD_ADD_RM64_R64  = 5'd4;
    localparam logic [4:0] CMD_ADD_R64_RM64  = 5'd5;
    localparam logic [4:0] CMD_MOV_RM16_R16  = 5'd6;
    localparam logic [4:0] CMD_MOV_R16_RM16  = 5'd7;
    localparam logic [4:0] CMD_MOV_RM32_R32  = 5'd8;
    localparam logic [4:0] CMD_MOV_R32_RM32  = 5'd9;
    localparam logic [4:0] CMD_MOV_RM64_R64  = 5'd10;
    localparam logic [4:0] CMD_MOV_R64_RM64  = 5'd11;
    localparam logic [4:0] CMD_MOV_R8_IMM8   = 5'd12;
    localparam logic [4:0] CMD_MOV_R16_IMM16 = 5'd13;
    localparam logic [4:0] CMD_MOV_R32_IMM32 = 5'd14;
    localparam logic [4:0] CMD_MOV_R64_IMM64 = 5'd15;
    localparam logic [4:0] CMD_MOV_RM8_IMM8  = 5'd16;
    localparam logic [4:0] CMD_MOV_RM16_IMM16 = 5'd17;
    localparam logic [4:0] CMD_MOV_RM32_IMM32 = 5'd18;

    typedef struct packed {
        logic       known;
        logic       pfx66;
        logic       wide;
        logic [7:0] opcode;
        logic [1:0] kind;
        logic [3:0] imm_n;
    } t_form;

    // Bytes of one instruction, first byte in bits 7:0.
    typedef struct packed {
        logic [FRAME_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
    } t_frame;

    typedef struct packed {
        logic free;
    } t_emit_status;

    function automatic t_form form_lookup(input logic [4:0] cmd);
        t_form f;
        f = '{known: 1'b1, pfx66: 1'b0, wide: 1'b0, opcode: OPC_ADD_RM_R,
              kind: KIND_MODRM_REG, imm_n: 4'd0};
        case (cmd)
            CMD_ADD_RM16_R16: begin f.pfx66 = 1'b1; f.opcode = OPC_ADD_RM_R; end
            CMD_ADD_R16_RM16: begin f.pfx66 = 1'b1; f.opcode = OPC_ADD_R_RM; end
            CMD_ADD_RM32_R32: f.opcode = OPC_ADD_RM_R;
            CMD_ADD_R32_RM32: f.opcode = OPC_ADD_R_RM;
            CMD_ADD_RM64_R64: begin f.wide = 1'b1; f.opcode = OPC_ADD_RM_R; end
            CMD_ADD_R64_RM64: begin f.wide = 1'b1; f.opcode = OPC_ADD_R_RM; end
            CMD_MOV_RM16_R16: begin f.pfx66 = 1'b1; f.opcode = OPC_MOV_RM_R; end
            CMD_MOV_R16_RM16: begin f.pfx66 = 1'b1; f.opcode = OPC_MOV_R_RM; end
            CMD_MOV_RM32_R32: f.opcode = OPC_MOV_RM_R;
            CMD_MOV_R32_RM32: f.opcode = OPC_MOV_R_RM;
            CMD_MOV_RM64_R64: begin f.wide = 1'b1; f.opcode = OPC_MOV_RM_R; end
            CMD_MOV_R64_RM64: begin f.wide = 1'b1; f.opcode = OPC_MOV_R_RM; end
            CMD_MOV_R8_IMM8: begin
                f.opcode = OPC_MOV_R8_I; f.kind = KIND_OPC_REG; f.imm_n = 4'd1;
            end
            CMD_MOV_R16_IMM16: begin
                f.pfx66 = 1'b1; f.opcode = OPC_MOV_R_I; f.kind = KIND_OPC_REG;
                f.imm_n = 4'd2;
            end
            CMD_MOV_R32_IMM32: begin
                f.opcode = OPC_MOV_R_I; f.kind = KIND_OPC_REG; f.imm_n = 4'd4;
            end
            CMD_MOV_R64_IMM64: begin
                f.wide = 1'b1; f.opcode = OPC_MOV_R_I; f.kind = KIND_OPC_REG;
                f.imm_n = 4'd8;
            end
            CMD_MOV_RM8_IMM8: begin
                f.opcode = OPC_MOV_RM8_I; f.kind = KIND_MODRM_IMM; f.imm_n = 4'd1;
            end
            CMD_MOV_RM16_IMM16: begin
                f.pfx66 = 1'b1; f.opcode = OPC_MOV_RM_I; f.kind = KIND_MODRM_IMM;
                f.imm_n = 4'd2;
            end
            CMD_MOV_RM32_IMM32: begin
                f.opcode = OPC_MOV_RM_I; f.kind = KIND_MODRM_IMM; f.imm_n = 4'd4;
            end
            default: f.known = 1'b0;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/x64e_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction requests and emitted bytes.
// Depends on nothing.
interface x64e_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cmd;
    logic [1:0]  mod_bits;
    logic [3:0]  rm_reg;
    logic [3:0]  reg_reg;
    logic [63:0] imm_value;

    modport source (output valid, cmd, mod_bits, rm_reg, reg_reg, imm_value,
                    input ready);
    modport sink (input valid, cmd, mod_bits, rm_reg, reg_reg, imm_value,
                  output ready);
endinterface

interface x64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ----- rtl/x64_instruction_byte_encoder.sv -----
`timescale 1ns / 1ps
// Top level: request register, decode and byte emitter of the x64 encoder.
// Depends on x64e_pkg, x64e_if, x64e_decode and x64e_emit.
//
//  Channel | Dir | Word                                         | Handshake
//  i_in    | in  | cmd, mod_bits, rm_reg, reg_reg, imm_value    | valid/ready
//  o_out   | out | out_byte, last_byte                          | valid/ready
//
// A request is held in the request register; its decoded bytes then leave one
// per cycle while the output is ready, 2 to 10 bytes per request.
// A new request is taken while the previous one's bytes are still going out.
// Unknown forms are dropped from the request register with no bytes.
// Synchronous active-low reset empties both registers; a stalled output holds.
module x64_instruction_byte_encoder
    import x64e_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    x64e_in_if.sink      i_in,
    x64e_out_if.source   o_out
);

    logic        r_valid;
    logic [4:0]  r_cmd;
    logic [1:0]  r_mod_bits;
    logic [3:0]  r_rm_reg;
    logic [3:0]  r_reg_reg;
    logic [63:0] r_imm_value;

    t_frame       frame;
    t_emit_status emit_st;
    logic         drain;
    logic         load;

    x64e_decode u_decode (
        .i_cmd       (r_cmd),
        .i_mod_bits  (r_mod_bits),
        .i_rm_reg    (r_rm_reg),
        .i_reg_reg   (r_reg_reg),
        .i_imm_value (r_imm_value),
        .o_frame     (frame)
    );

    // A request with no bytes leaves the register without touching the emitter.
    assign drain      = r_valid && ((frame.count == '0) || emit_st.free);
    assign load       = r_valid && (frame.count != '0) && emit_st.free;
    assign i_in.ready = !r_valid || drain;

    x64e_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_frame  (frame),
        .o_status (emit_st),
        .o_out    (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_cmd       <= i_in.cmd;
            r_mod_bits  <= i_in.mod_bits;
            r_rm_reg    <= i_in.rm_reg;
            r_reg_reg   <= i_in.reg_reg;
            r_imm_value <= i_in.imm_value;
        end
    end

endmodule

// ----- rtl/x64e_decode.sv -----
`timescale 1ns / 1ps
// Combinational decode of one registered request into its packed byte frame.
// Depends on x64e_pkg.
module x64e_decode
    import x64e_pkg::*;
(
    input  logic [4:0]  i_cmd,
    input  logic [1:0]  i_mod_bits,
    input  logic [3:0]  i_rm_reg,
    input  logic [3:0]  i_reg_reg,
    input  logic [63:0] i_imm_value,
    output t_frame      o_frame
);

    t_form       form;
    logic [3:0]  rex_bits;
    logic        has_rex;
    logic        has_modrm;
    logic [7:0]  opc;
    logic [7:0]  modrm;
    logic [31:0] hdr;
    logic [2:0]  hdr_len;
    logic [63:0] imm_masked;

    always_comb begin
        form      = form_lookup(i_cmd);
        has_modrm = (form.kind != KIND_OPC_REG);
        rex_bits  = {form.wide,
                     (form.kind == KIND_MODRM_REG) && i_reg_reg[3],
                     1'b0,
                     (form.kind == KIND_OPC_REG) ? i_reg_reg[3] : i_rm_reg[3]};
        has_rex   = (rex_bits != 4'd0);
        opc       = (form.kind == KIND_OPC_REG) ?
                    form.opcode + {5'd0, i_reg_reg[2:0]} : form.opcode;
        modrm     = {i_mod_bits,
                     (form.kind == KIND_MODRM_REG) ? i_reg_reg[2:0] : 3'd0,
                     i_rm_reg[2:0]};

        // Prefix bytes are prepended at the low end, so each one pushes the rest up.
        hdr     = has_modrm ? {16'd0, modrm, opc} : {24'd0, opc};
        hdr_len = has_modrm ? 3'd2 : 3'd1;
        if (has_rex) begin
            hdr     = {hdr[23:0], REX_BASE | {4'd0, rex_bits}};
            hdr_len = hdr_len + 3'd1;
        end
        if (form.pfx66) begin
            hdr     = {hdr[23:0], PFX_OPSIZE};
            hdr_len = hdr_len + 3'd1;
        end

        case (form.imm_n)
            4'd1:    imm_masked = {56'd0, i_imm_value[7:0]};
            4'd2:    imm_masked = {48'd0, i_imm_value[15:0]};
            4'd4:    imm_masked = {32'd0, i_imm_value[31:0]};
            4'd8:    imm_masked = i_imm_value;
            default: imm_masked = 64'd0;
        endcase

        o_frame.bytes = ({16'd0, imm_masked} << {hdr_len, 3'b000})
                        | {48'd0, hdr};
        o_frame.count = form.known ? ({1'b0, hdr_len} + form.imm_n) : '0;
    end

endmodule

// ----- rtl/x64e_emit.sv -----
`timescale 1ns / 1ps
// Output frame register that shifts one byte per accepted output word.
// Depends on x64e_pkg and x64e_if.
module x64e_emit
    import x64e_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_frame        i_frame,
    output t_emit_status  o_status,
    x64e_out_if.source    o_out
);

    logic [FRAME_W-1:0] r_bytes, n_bytes;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               fire;

    assign fire              = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_bytes[7:0];
    assign o_out.last_byte   = (r_cnt == CNT_W'(1));
    assign o_status.free     = (r_cnt == '0) || (fire && o_out.last_byte);

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        if (i_load) begin
            n_bytes = i_frame.bytes;
            n_cnt   = i_frame.count;
        end else if (fire) begin
            n_bytes = {8'd0, r_bytes[FRAME_W-1:8]};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bytes <= n_bytes;
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_status.free)
        else $error("frame loaded over unfinished bytes");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_frame.count != '0))
        else $error("empty frame loaded");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("byte count beyond instruction length");

    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cnt > CNT_W'(1)) |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("byte count did not step down");

endmodule
